// File: hdl/tsc_pkg.sv
package tsc_pkg;

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_FWD  = 3'd1;
  localparam logic [2:0] SQ_EXT  = 3'd2;
  localparam logic [2:0] SQ_BACK = 3'd3;
  localparam logic [2:0] SQ_RET  = 3'd4;
  localparam logic [2:0] SQ_DONE = 3'd5;

  localparam logic [1:0] MV_STOP = 2'd0;
  localparam logic [1:0] MV_EXT  = 2'd1;
  localparam logic [1:0] MV_RET  = 2'd2;

  localparam logic [1:0] GOAL_NONE = 2'd0;
  localparam logic [1:0] GOAL_EXT  = 2'd1;
  localparam logic [1:0] GOAL_RET  = 2'd2;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_BACK = 2'd2;
  localparam logic [1:0] CMD_HOLD = 2'd3;

  localparam logic MODE_VEHICLE = 1'b0;
  localparam logic MODE_FLIGHT  = 1'b1;

  localparam logic REG_PULSE_WIDTH = 1'b0;
  localparam logic REG_OP_DELAY    = 1'b1;

  localparam logic [15:0] PULSE_WIDTH_RESET = 16'd100;
  localparam logic [15:0] OP_DELAY_RESET    = 16'd2000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        transform_mode;
    logic        jam_report;
    logic        servo_holding;
  } in_item_t;

  typedef struct packed {
    logic       line_level;
    logic [1:0] motor_command;
    logic [2:0] sequence_phase;
    logic [1:0] actuator_motion_now;
  } out_item_t;

  typedef struct packed {
    logic [2:0] seq;
    logic       prev_mode;
    logic [1:0] phase;
    logic [1:0] motion;
    logic [1:0] goal;
    logic       pulse_active;
    logic       jam;
    logic [1:0] cmd;
  } ctl_t;

  function automatic logic at_goal(input logic [1:0] goal, input logic [1:0] motion,
                                   input logic [1:0] phase);
    logic r;
    r = 1'b1;
    if (goal == GOAL_EXT) begin
      r = (motion == MV_EXT) || (motion == MV_STOP && phase == 2'd2);
    end else if (goal == GOAL_RET) begin
      r = (motion == MV_RET) || (motion == MV_STOP && phase == 2'd0);
    end
    return r;
  endfunction

endpackage

// File: hdl/transform_sequence_controller.sv
// Transform sequence controller: takes one control tick per clock cycle unless out_stall
// holds a waiting result, and returns one result per tick (input, then result register).
// The whole tick is one pass of next-state logic whose longest path is the two
// TIME_BITS-wide elapsed-time subtract-compares. While a finished result waits under
// out_stall, one more tick is taken into the input register; after that in_stall follows
// out_stall. Write the pulse width and operation delay registers only while no tick is
// in flight.
module transform_sequence_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tsc_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import tsc_pkg::*;

  logic                 in_full;
  in_item_t             in_q;
  logic                 advance;

  logic [15:0]          pulse_width_ms;
  logic [15:0]          operation_delay_ms;

  ctl_t                 ctl;
  ctl_t                 ctl_next;
  logic [TIME_BITS-1:0] pulse_start;
  logic [TIME_BITS-1:0] pulse_start_next;
  logic [TIME_BITS-1:0] op_start;
  logic [TIME_BITS-1:0] op_start_next;
  out_item_t            result;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  tsc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .item              (in_q),
    .ctl               (ctl),
    .pulse_start       (pulse_start),
    .op_start          (op_start),
    .pulse_width_ms    (pulse_width_ms),
    .operation_delay_ms(operation_delay_ms),
    .ctl_next          (ctl_next),
    .pulse_start_next  (pulse_start_next),
    .op_start_next     (op_start_next),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_ms     <= PULSE_WIDTH_RESET;
      operation_delay_ms <= OP_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_WIDTH: pulse_width_ms     <= cfg_data;
        REG_OP_DELAY:    operation_delay_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.seq          <= SQ_IDLE;
      ctl.prev_mode    <= MODE_VEHICLE;
      ctl.phase        <= 2'd0;
      ctl.motion       <= MV_STOP;
      ctl.goal         <= GOAL_NONE;
      ctl.pulse_active <= 1'b0;
      ctl.jam          <= 1'b0;
      ctl.cmd          <= CMD_NONE;
      pulse_start      <= '0;
      op_start         <= '0;
    end else if (advance) begin
      ctl         <= ctl_next;
      pulse_start <= pulse_start_next;
      op_start    <= op_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  a_motion_phase: assert property (@(posedge clk) disable iff (rst)
    ((ctl.motion == MV_EXT) == (ctl.phase == 2'd1)) &&
    ((ctl.motion == MV_RET) == (ctl.phase == 2'd3)))
    else $error("actuator motion out of step with pulse phase");

  a_rotate_cmd: assert property (@(posedge clk) disable iff (rst)
    (ctl.seq == SQ_FWD || ctl.seq == SQ_BACK) |-> (ctl.cmd != CMD_NONE))
    else $error("rotating without a motor command");

  a_line_level: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_item.line_level == !ctl.pulse_active))
    else $error("line level does not match pulse state");

endmodule

// File: hdl/tsc_step.sv
module tsc_step #(
  parameter int TIME_BITS = 32
) (
  input  tsc_pkg::in_item_t   item,
  input  tsc_pkg::ctl_t       ctl,
  input  logic [TIME_BITS-1:0] pulse_start,
  input  logic [TIME_BITS-1:0] op_start,
  input  logic [15:0]          pulse_width_ms,
  input  logic [15:0]          operation_delay_ms,
  output tsc_pkg::ctl_t       ctl_next,
  output logic [TIME_BITS-1:0] pulse_start_next,
  output logic [TIME_BITS-1:0] op_start_next,
  output tsc_pkg::out_item_t  result
);
  import tsc_pkg::*;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] pulse_age;
  logic [TIME_BITS-1:0] op_age;
  logic                 pulse_over;
  logic                 op_aged;

  assign now        = TIME_BITS'(item.now_ms);
  assign pulse_age  = now - pulse_start;
  assign op_age     = now - op_start;
  assign pulse_over = pulse_age >= TIME_BITS'(pulse_width_ms);
  assign op_aged    = op_age >= TIME_BITS'(operation_delay_ms);

  always_comb begin
    ctl_t c;
    logic pa_mid;
    logic began;
    logic delay_ok;

    c = ctl;
    began = 1'b0;

    if (c.pulse_active && pulse_over) begin
      c.pulse_active = 1'b0;
    end
    pa_mid = c.pulse_active;

    if (item.jam_report) begin
      c.jam = 1'b1;
    end

    if (item.transform_mode != c.prev_mode) begin
      if (item.transform_mode == MODE_FLIGHT) begin
        c.seq = SQ_FWD;
        c.jam = 1'b0;
        c.cmd = CMD_FWD;
      end else begin
        c.seq  = SQ_RET;
        c.goal = GOAL_RET;
        began  = 1'b1;
        if (!at_goal(c.goal, c.motion, c.phase) && !c.pulse_active) begin
          c.pulse_active = 1'b1;
          c.phase = c.phase + 2'd1;
          c.motion = (c.phase == 2'd1) ? MV_EXT : (c.phase == 2'd3) ? MV_RET : MV_STOP;
        end
      end
      c.prev_mode = item.transform_mode;
    end

    // op start moves to now when an actuator operation begins this tick
    delay_ok = began ? (operation_delay_ms == 16'd0) : op_aged;

    case (c.seq)
      SQ_FWD: begin
        if (c.jam) begin
          c.cmd  = CMD_HOLD;
          c.seq  = SQ_EXT;
          c.goal = GOAL_EXT;
          began  = 1'b1;
          if (!at_goal(c.goal, c.motion, c.phase) && !c.pulse_active) begin
            c.pulse_active = 1'b1;
            c.phase = c.phase + 2'd1;
            c.motion = (c.phase == 2'd1) ? MV_EXT : (c.phase == 2'd3) ? MV_RET : MV_STOP;
          end
        end else if (item.servo_holding) begin
          c.cmd = CMD_FWD;
        end
      end
      SQ_EXT, SQ_RET: begin
        if (!at_goal(c.goal, c.motion, c.phase) && !c.pulse_active &&
            c.goal != GOAL_NONE) begin
          c.pulse_active = 1'b1;
          c.phase = c.phase + 2'd1;
          c.motion = (c.phase == 2'd1) ? MV_EXT : (c.phase == 2'd3) ? MV_RET : MV_STOP;
        end
        if (delay_ok && at_goal(c.goal, c.motion, c.phase)) begin
          c.goal = GOAL_NONE;
          if (c.seq == SQ_EXT) begin
            c.seq = SQ_DONE;
          end else begin
            c.seq = SQ_BACK;
            c.jam = 1'b0;
            c.cmd = CMD_BACK;
          end
        end
      end
      SQ_BACK: begin
        if (c.jam) begin
          c.cmd = CMD_HOLD;
          c.seq = SQ_DONE;
        end else if (item.servo_holding) begin
          c.cmd = CMD_BACK;
        end
      end
      SQ_DONE: begin
        c.goal = GOAL_NONE;
        c.seq  = SQ_IDLE;
      end
      default: begin
      end
    endcase

    ctl_next = c;
    pulse_start_next = (c.pulse_active && !pa_mid) ? now : pulse_start;
    op_start_next    = began ? now : op_start;

    result.line_level          = !c.pulse_active;
    result.motor_command       = c.cmd;
    result.sequence_phase      = c.seq;
    result.actuator_motion_now = c.motion;
  end

endmodule
